FILE: rtl/fpgs_pkg.sv
// ----------------------------------------------------------------------------
// fpgs_pkg : shared types, constants and rule tables
// Fixed-point constants, multiplier request type and the two 7x7 rule bases
// of the fuzzy PD gain scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package fpgs_pkg;

    // Fuzzy level count and index width
    localparam int NUM_LEVELS = 7;
    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int RULE_W     = 3;

    // Field and register widths
    localparam int ERR_W   = 16;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int SCALE_W = 32;
    localparam int SPAN_W  = 16;
    localparam int GAIN_W  = 17;
    localparam int WGT_W   = 17;                 // Q16 weight, 0..65536
    localparam int EV_W    = ERR_W + SCALE_W;    // magnitude of a scaled value
    localparam int INNER_W = 19;                 // weight times rule, 0..6*65536
    localparam int ACC_W   = 35;                 // Q32 weight product times rule
    localparam int Y_W     = 19;                 // span * acc >> 32
    localparam int Q_W     = 16;                 // fuzzy part of a gain

    // Shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ERROR_SCALE = 3'd0;
    localparam t_cfg_idx CFG_RATE_SCALE  = 3'd1;
    localparam t_cfg_idx CFG_KP_SPAN     = 3'd2;
    localparam t_cfg_idx CFG_KD_SPAN     = 3'd3;
    localparam t_cfg_idx CFG_KP_BASE     = 3'd4;
    localparam t_cfg_idx CFG_KD_BASE     = 3'd5;

    // Register reset values
    localparam logic [SCALE_W-1:0] ERROR_SCALE_RST = 32'd9830;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 32'd196608;
    localparam logic [SPAN_W-1:0]  KP_SPAN_RST     = 16'd512;
    localparam logic [SPAN_W-1:0]  KD_SPAN_RST     = 16'd2560;
    localparam logic [SPAN_W-1:0]  KP_BASE_RST     = 16'd0;
    localparam logic [SPAN_W-1:0]  KD_BASE_RST     = 16'd0;

    // Q16 breakpoints: error knee at 3.5, error top at 6.0, rate ends at +/-3.0
    localparam logic [WGT_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic [EV_W-1:0]  ERR_KNEE = 48'd229376;
    localparam logic [EV_W-1:0]  ERR_TOP  = 48'd393216;
    localparam logic [EV_W-1:0]  RATE_TOP = 48'd196608;

    // Reciprocal constants: floor(x/7) for x < 2^19, floor(x/3) for x < 2^18
    localparam logic [MUL_W-1:0] DIV7_MUL   = 32'd599187;
    localparam int               DIV7_SHIFT = 22;
    localparam logic [MUL_W-1:0] DIV3_MUL   = 32'd349526;
    localparam int               DIV3_SHIFT = 20;

    // Operand pair for the shared multiplier
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    // One row of a rule base, element d is the rule for change level d
    typedef logic [NUM_LEVELS-1:0][RULE_W-1:0] t_rule_row;

    // Proportional rule base, row chosen by error level
    function automatic t_rule_row kp_row(input logic [LVL_W-1:0] e);
        t_rule_row row;
        case (e)
            LVL_W'(0): row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
            LVL_W'(1): row = {3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
            LVL_W'(2): row = {3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1};
            LVL_W'(3): row = {3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2};
            LVL_W'(4): row = {3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3};
            LVL_W'(5): row = {3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4};
            LVL_W'(6): row = {3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6};
            default:   row = '0;
        endcase
        return row;
    endfunction

    // Derivative rule base, row chosen by error level
    function automatic t_rule_row kd_row(input logic [LVL_W-1:0] e);
        t_rule_row row;
        case (e)
            LVL_W'(0): row = {3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd6};
            LVL_W'(1): row = {3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd6};
            LVL_W'(2): row = {3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6};
            LVL_W'(3): row = {3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5};
            LVL_W'(4): row = {3'd0, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4};
            LVL_W'(5): row = {3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3};
            LVL_W'(6): row = {3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3};
            default:   row = '0;
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fpgs_mul.sv
// ----------------------------------------------------------------------------
// fpgs_mul : shared unsigned multiplier
// 32 x 32 unsigned multiply with a registered 64-bit product, one request
// per cycle, product valid on the following cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpgs_mul (
    input  logic                        i_clk,
    input  fpgs_pkg::t_mul_req          i_req,
    output logic [fpgs_pkg::PROD_W-1:0] o_prod
);
    import fpgs_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: rtl/fuzzy_pd_gain_scheduler.sv
// ----------------------------------------------------------------------------
// fuzzy_pd_gain_scheduler : fuzzy self-tuning PD gain scheduler
// Items are taken one at a time: the sequencer takes a new item only in idle,
// after eleven passes through the one shared 32x32 multiplier; the output
// register holds a result while the next item is taken.
// Reset (synchronous, active low): sequencer idle, no result pending,
// previous error zero, registers at their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module fuzzy_pd_gain_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input items
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,   // [15:0] error_sample
    // Result items
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [39:0]                  m_axis_tdata,   // [16:0] prop_gain,
                                                         // [33:17] deriv_gain
    // Register writes
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  fpgs_pkg::t_cfg_idx           i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);
    import fpgs_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL_E = 4'd1;
    localparam logic [3:0] S_MUL_D = 4'd2;
    localparam logic [3:0] S_DIV7  = 4'd3;
    localparam logic [3:0] S_EW    = 4'd4;
    localparam logic [3:0] S_W0    = 4'd5;
    localparam logic [3:0] S_W1    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_SPM   = 4'd8;
    localparam logic [3:0] S_Y     = 4'd9;
    localparam logic [3:0] S_D3    = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // Configuration registers
    logic [SCALE_W-1:0] r_error_scale, r_rate_scale;
    logic [SPAN_W-1:0]  r_kp_span, r_kd_span, r_kp_base, r_kd_base;

    // Sequencer and datapath registers
    logic [3:0]         r_state, n_state;
    logic               r_tbl, n_tbl;
    logic [ERR_W-1:0]   r_prev_err, n_prev_err;
    logic [ERR_W-1:0]   r_e_mag, n_e_mag;
    logic [ERR_W-1:0]   r_d_mag, n_d_mag;
    logic               r_d_neg, n_d_neg;
    logic               r_osc, n_osc;
    logic [LVL_W-1:0]   r_ei, n_ei;
    logic [WGT_W-1:0]   r_ew, n_ew;
    logic               r_div7, n_div7;
    logic [INNER_W-1:0] r_v2, n_v2;
    logic [LVL_W-1:0]   r_di, n_di;
    logic [WGT_W-1:0]   r_dw, n_dw;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [Y_W-1:0]     r_y, n_y;
    logic [GAIN_W-1:0]  r_kp, n_kp;
    logic [GAIN_W-1:0]  r_kd, n_kd;
    logic               r_out_valid, n_out_valid;
    logic [GAIN_W-1:0]  r_out_prop, n_out_prop;
    logic [GAIN_W-1:0]  r_out_deriv, n_out_deriv;

    // Shared multiplier
    t_mul_req           mul_req;
    logic [PROD_W-1:0]  mul_prod;

    // Item intake
    logic [DIFF_W-1:0]  diff, neg_diff;
    logic [ERR_W-1:0]   neg_err;
    logic               flip, err_pos, prev_pos;

    // Membership results
    logic [LVL_W-1:0]   em_ei;
    logic [WGT_W-1:0]   em_ew;
    logic               em_div7;
    logic [INNER_W-1:0] em_v2;
    logic [INNER_W-1:0] em_seg;
    logic [LVL_W-1:0]   rm_di;
    logic [WGT_W-1:0]   rm_dw;
    logic [INNER_W-1:0] rm_u;

    // Rule weighting
    logic [LVL_W-1:0]   rule_e;
    logic [LVL_W-1:0]   di_hi;
    t_rule_row          rule_row;
    logic [WGT_W-1:0]   dw_lo, ew_lo;
    logic [INNER_W-1:0] inner;
    logic [SPAN_W-1:0]  span_sel, base_sel;
    logic [GAIN_W-1:0]  gain_val;

    fpgs_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    // Register writes, always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_scale <= ERROR_SCALE_RST;
            r_rate_scale  <= RATE_SCALE_RST;
            r_kp_span     <= KP_SPAN_RST;
            r_kd_span     <= KD_SPAN_RST;
            r_kp_base     <= KP_BASE_RST;
            r_kd_base     <= KD_BASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ERROR_SCALE: r_error_scale <= i_cfg_data;
                CFG_RATE_SCALE:  r_rate_scale  <= i_cfg_data;
                CFG_KP_SPAN:     r_kp_span     <= i_cfg_data[SPAN_W-1:0];
                CFG_KD_SPAN:     r_kd_span     <= i_cfg_data[SPAN_W-1:0];
                CFG_KP_BASE:     r_kp_base     <= i_cfg_data[SPAN_W-1:0];
                CFG_KD_BASE:     r_kd_base     <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // Error change, magnitudes, sign flip and oscillation detect
    assign diff     = {s_axis_tdata[ERR_W-1], s_axis_tdata}
                    - {r_prev_err[ERR_W-1], r_prev_err};
    assign neg_diff = '0 - diff;
    assign neg_err  = '0 - s_axis_tdata;
    assign flip     = s_axis_tdata[ERR_W-1] && (r_error_scale != '0);
    assign err_pos  = !s_axis_tdata[ERR_W-1] && (s_axis_tdata != '0);
    assign prev_pos = !r_prev_err[ERR_W-1] && (r_prev_err != '0);

    // Error membership from the scaled error magnitude
    assign em_seg = mul_prod[INNER_W-1:0] - ERR_KNEE[INNER_W-1:0];

    always_comb begin
        em_ei   = '0;
        em_ew   = '0;
        em_div7 = 1'b0;
        em_v2   = {mul_prod[INNER_W-2:0], 1'b0};
        if (mul_prod[EV_W-1:0] == '0) begin
            em_ew = '0;
        end else if (mul_prod[EV_W-1:0] >= ERR_TOP) begin
            em_ei = LVL_W'(NUM_LEVELS - 2);
            em_ew = Q16_ONE;
        end else if (mul_prod[EV_W-1:0] < ERR_KNEE) begin
            // wide first segment: weight is 2v/7, taken by reciprocal
            em_div7 = 1'b1;
        end else begin
            // half-unit segments: weight is twice the offset
            em_ei = LVL_W'(1) + em_seg[17:15];
            em_ew = {1'b0, em_seg[14:0], 1'b0};
        end
    end

    // Change membership from the scaled change magnitude and sign
    assign rm_u = r_d_neg ? (RATE_TOP[INNER_W-1:0] - mul_prod[INNER_W-1:0])
                          : (RATE_TOP[INNER_W-1:0] + mul_prod[INNER_W-1:0]);

    always_comb begin
        rm_di = rm_u[18:16];
        rm_dw = {1'b0, rm_u[15:0]};
        if (r_osc || (!r_d_neg && (mul_prod[EV_W-1:0] >= RATE_TOP))) begin
            rm_di = LVL_W'(NUM_LEVELS - 2);
            rm_dw = Q16_ONE;
        end else if (r_d_neg && (mul_prod[EV_W-1:0] >= RATE_TOP)) begin
            rm_di = '0;
            rm_dw = '0;
        end
    end

    // Rule lookup and change weighting for one error level
    assign rule_e   = (r_state == S_W1) ? (r_ei + LVL_W'(1)) : r_ei;
    assign rule_row = r_tbl ? kd_row(rule_e) : kp_row(rule_e);
    assign di_hi    = r_di + LVL_W'(1);
    assign dw_lo    = Q16_ONE - r_dw;
    assign ew_lo    = Q16_ONE - r_ew;
    assign inner    = INNER_W'(dw_lo) * INNER_W'(rule_row[r_di])
                    + INNER_W'(r_dw) * INNER_W'(rule_row[di_hi]);

    assign span_sel = r_tbl ? r_kd_span : r_kp_span;
    assign base_sel = r_tbl ? r_kd_base : r_kp_base;
    // sum of two 16-bit values always fits the 17-bit gain, so no clamp hits
    assign gain_val = GAIN_W'(base_sel) + GAIN_W'(mul_prod[DIV3_SHIFT +: Q_W]);

    // Multiplier operands per step
    always_comb begin
        mul_req = '0;
        case (r_state)
            S_MUL_E: begin
                mul_req.a = MUL_W'(r_e_mag);
                mul_req.b = r_error_scale;
            end
            S_MUL_D: begin
                mul_req.a = MUL_W'(r_d_mag);
                mul_req.b = r_rate_scale;
            end
            S_DIV7: begin
                mul_req.a = MUL_W'(r_v2);
                mul_req.b = DIV7_MUL;
            end
            S_W0: begin
                mul_req.a = MUL_W'(ew_lo);
                mul_req.b = MUL_W'(inner);
            end
            S_W1: begin
                mul_req.a = MUL_W'(r_ew);
                mul_req.b = MUL_W'(inner);
            end
            S_SPM: begin
                mul_req.a = MUL_W'(span_sel);
                mul_req.b = r_acc[MUL_W-1:0];
            end
            S_D3: begin
                mul_req.a = MUL_W'(r_y[Y_W-1:1]);
                mul_req.b = DIV3_MUL;
            end
            default: mul_req = '0;
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_tbl       = r_tbl;
        n_prev_err  = r_prev_err;
        n_e_mag     = r_e_mag;
        n_d_mag     = r_d_mag;
        n_d_neg     = r_d_neg;
        n_osc       = r_osc;
        n_ei        = r_ei;
        n_ew        = r_ew;
        n_div7      = r_div7;
        n_v2        = r_v2;
        n_di        = r_di;
        n_dw        = r_dw;
        n_acc       = r_acc;
        n_y         = r_y;
        n_kp        = r_kp;
        n_kd        = r_kd;
        n_out_valid = r_out_valid;
        n_out_prop  = r_out_prop;
        n_out_deriv = r_out_deriv;

        // drop the result once taken
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_prev_err = s_axis_tdata;
                    n_e_mag    = s_axis_tdata[ERR_W-1] ? neg_err : s_axis_tdata;
                    n_d_mag    = diff[DIFF_W-1] ? neg_diff[ERR_W-1:0] : diff[ERR_W-1:0];
                    n_d_neg    = diff[DIFF_W-1] ^ flip;
                    n_osc      = (r_prev_err[ERR_W-1] && err_pos)
                              || (prev_pos && s_axis_tdata[ERR_W-1]);
                    n_tbl      = 1'b0;
                    n_state    = S_MUL_E;
                end
            end
            S_MUL_E: n_state = S_MUL_D;
            S_MUL_D: begin
                n_ei    = em_ei;
                n_ew    = em_ew;
                n_div7  = em_div7;
                n_v2    = em_v2;
                n_state = S_DIV7;
            end
            S_DIV7: begin
                n_di    = rm_di;
                n_dw    = rm_dw;
                n_state = S_EW;
            end
            S_EW: begin
                if (r_div7) begin
                    n_ew = mul_prod[DIV7_SHIFT +: WGT_W];
                end
                n_state = S_W0;
            end
            S_W0: n_state = S_W1;
            S_W1: begin
                n_acc   = mul_prod[ACC_W-1:0];
                n_state = S_SUM;
            end
            S_SUM: begin
                n_acc   = r_acc + mul_prod[ACC_W-1:0];
                n_state = S_SPM;
            end
            S_SPM: n_state = S_Y;
            S_Y: begin
                // span * acc >> 32, with the top bits of acc added back in
                n_y     = Y_W'(span_sel) * Y_W'(r_acc[ACC_W-1:MUL_W])
                        + Y_W'(mul_prod[MUL_W +: SPAN_W]);
                n_state = S_D3;
            end
            S_D3: n_state = S_FIN;
            S_FIN: begin
                if (r_tbl) begin
                    n_kd    = gain_val;
                    n_state = S_OUT;
                end else begin
                    n_kp    = gain_val;
                    n_tbl   = 1'b1;
                    n_state = S_W0;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_prop  = r_kp;
                    n_out_deriv = r_kd;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tbl       <= 1'b0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tbl       <= n_tbl;
            r_prev_err  <= n_prev_err;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_e_mag     <= n_e_mag;
        r_d_mag     <= n_d_mag;
        r_d_neg     <= n_d_neg;
        r_osc       <= n_osc;
        r_ei        <= n_ei;
        r_ew        <= n_ew;
        r_div7      <= n_div7;
        r_v2        <= n_v2;
        r_di        <= n_di;
        r_dw        <= n_dw;
        r_acc       <= n_acc;
        r_y         <= n_y;
        r_kp        <= n_kp;
        r_kd        <= n_kd;
        r_out_prop  <= n_out_prop;
        r_out_deriv <= n_out_deriv;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_deriv, r_out_prop};

    // Sequencer leaves idle once an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still ready after an item was taken");

    // Memberships stay on the level grid with weights within one
    a_member_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_W0) |-> ((r_ew <= Q16_ONE) && (r_dw <= Q16_ONE)
            && (r_ei <= LVL_W'(NUM_LEVELS - 2)) && (r_di <= LVL_W'(NUM_LEVELS - 2))))
        else $error("membership out of range");

    // A result is only raised from the output step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == S_OUT))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

FILE: tb/tb_fuzzy_pd_gain_scheduler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fuzzy_pd_gain_scheduler : self-checking bench for the gain scheduler
// A short table of error samples runs under the reset settings, then random
// error sequences run under six register settings. A local model of the
// fuzzy inference predicts both gains per unpinned item taken, and each result
// is compared with the oldest prediction. Both stream sides idle in random
// bursts; the closing stretch of the run runs at full rate.
// ----------------------------------------------------------------------------

module tb_fuzzy_pd_gain_scheduler;

    // Register indexes with no register behind them
    localparam fpgs_pkg::t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam fpgs_pkg::t_cfg_idx CFG_SPARE_HI = 3'd7;

    // Fixed-point constants of the inference
    localparam longint          Q16_UNIT     = 65536;
    localparam longint          ERR_KNEE_Q16 = 229376;     // 3.5
    localparam longint          ERR_STEP_Q16 = 32768;      // 0.5 above the knee
    localparam longint          RATE_STEP_Q16 = 65536;     // 1.0
    localparam longint          RATE_END_Q16 = 196608;     // 3.0
    localparam longint unsigned FULL_SCALE   = 64'd6 << 32;
    localparam longint unsigned GAIN_CEIL    = 131071;

    localparam int STEPS_PER_PHASE = 205;
    localparam int NUM_PHASES      = 6;
    localparam int CALM_STEPS      = 100;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 40;

    // Rule bases, row = error level, column = change level
    localparam bit [0:48][2:0] KP_RULES = {
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
        3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5,
        3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6 };
    localparam bit [0:48][2:0] KD_RULES = {
        3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2,
        3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2,
        3'd6, 3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2,
        3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1,
        3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0,
        3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0,
        3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0 };

    typedef struct packed {
        logic [16:0] prop;
        logic [16:0] deriv;
    } t_gain_pair;

    typedef struct packed {
        logic [15:0] sample;
        logic        pinned;     // gains below are the known answer
        logic [16:0] prop;
        logic [16:0] deriv;
    } t_step_row;

    // Opening steps under the reset settings
    localparam int OPENING_COUNT = 22;
    localparam t_step_row [0:OPENING_COUNT-1] OPENING_STEPS = {
        {16'sd0,      1'b1, 17'd0,   17'd1706},  // zero error from reset
        {16'sd0,      1'b1, 17'd0,   17'd1706},
        {16'sd1,      1'b0, 17'd0,   17'd0},     // unit rise, change at top
        {16'sd2,      1'b0, 17'd0,   17'd0},
        {16'sd1,      1'b0, 17'd0,   17'd0},     // unit fall, change at bottom
        {16'sd23,     1'b0, 17'd0,   17'd0},     // just below the error knee
        {16'sd24,     1'b0, 17'd0,   17'd0},     // just above the error knee
        {16'sd40,     1'b0, 17'd0,   17'd0},     // just below the error top
        {16'sd41,     1'b1, 17'd512, 17'd0},     // error and change above range
        {16'sd41,     1'b0, 17'd0,   17'd0},     // zero change
        {-16'sd32768, 1'b1, 17'd512, 17'd0},     // sign swap, most negative
        {-16'sd32768, 1'b0, 17'd0,   17'd0},     // flipped, zero change
        {-16'sd5,     1'b0, 17'd0,   17'd0},     // flipped rise
        {-16'sd6,     1'b0, 17'd0,   17'd0},     // flipped fall
        {16'sd0,      1'b0, 17'd0,   17'd0},     // back to zero, no swap
        {16'sd32767,  1'b1, 17'd512, 17'd0},     // most positive from zero
        {-16'sd1,     1'b0, 17'd0,   17'd0},     // sign swap
        {16'sd1,      1'b0, 17'd0,   17'd0},     // sign swap
        {16'sd21845,  1'b0, 17'd0,   17'd0},
        {-16'sd21846, 1'b0, 17'd0,   17'd0},
        {16'sd32767,  1'b0, 17'd0,   17'd0},
        {-16'sd32768, 1'b1, 17'd512, 17'd0} };   // full-scale sign swap

    // Block ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;     // [15:0] error_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;     // [16:0] prop_gain, [33:17] deriv_gain
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    fpgs_pkg::t_cfg_idx    i_cfg_index;
    logic [31:0]           i_cfg_data;

    // Model state: registers and the held error
    logic [31:0]           error_scale_q16;
    logic [31:0]           rate_scale_q16;
    logic [15:0]           kp_span_q8;
    logic [15:0]           kd_span_q8;
    logic [15:0]           kp_base_q8;
    logic [15:0]           kd_base_q8;
    logic signed [15:0]    held_error;

    t_gain_pair            pending_gains [$];
    logic                  pin_valid;
    t_gain_pair            pin_gains;
    logic [15:0]           sent_error;
    bit                    calm;
    int                    sink_burst;
    int                    idle_cycles;
    int                    fault_count;

    fuzzy_pd_gain_scheduler uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 250 MHz clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Breakpoint i of the error universe (0..6) or the change universe (-3..3)
    function automatic longint knot(input bit on_rate, input int i);
        if (on_rate)
            return (i - 3) * RATE_STEP_Q16;
        return (i == 0) ? 0 : ERR_KNEE_Q16 + (i - 1) * ERR_STEP_Q16;
    endfunction

    // Triangular membership: lower level and the Q16 weights of it and the next
    function automatic void membership(input longint v, input bit on_rate,
                                       output int lo, output longint unsigned w_lo,
                                       output longint unsigned w_hi);
        longint b0;
        longint b1;
        bit     found;
        lo = 0;
        w_lo = Q16_UNIT;
        w_hi = 0;
        found = 0;
        if (v >= knot(on_rate, 6)) begin
            lo = 5;
            w_lo = 0;
            w_hi = Q16_UNIT;
        end else if (v > knot(on_rate, 0)) begin
            for (int i = 0; i < 6; i++) begin
                b0 = knot(on_rate, i);
                b1 = knot(on_rate, i + 1);
                if (!found && v <= b1) begin
                    found = 1;
                    lo = i;
                    w_hi = ((v - b0) <<< 16) / (b1 - b0);
                    w_lo = Q16_UNIT - w_hi;
                end
            end
        end
    endfunction

    function automatic logic [16:0] saturate_gain(input longint unsigned g);
        return (g > GAIN_CEIL) ? GAIN_CEIL[16:0] : g[16:0];
    endfunction

    // Gains for one error sample against the held error and current registers
    function automatic t_gain_pair schedule_gains(input logic signed [15:0] sample);
        int                cur;
        int                prev;
        longint            ev;
        longint            dv;
        int                e_lo;
        int                d_lo;
        longint unsigned   ew [2];
        longint unsigned   dw [2];
        longint unsigned   wp;
        longint unsigned   acc_p;
        longint unsigned   acc_d;
        t_gain_pair        r;
        cur = int'(sample);
        prev = int'(held_error);
        ev = longint'(cur) * longint'(error_scale_q16);
        dv = longint'(cur - prev) * longint'(rate_scale_q16);
        // Mirror negative errors onto the positive half
        if (ev < 0) begin
            ev = -ev;
            dv = -dv;
        end
        // Force the change to the top when the error swaps sign
        if ((prev < 0 && cur > 0) || (prev > 0 && cur < 0))
            dv = RATE_END_Q16;
        membership(ev, 1'b0, e_lo, ew[0], ew[1]);
        membership(dv, 1'b1, d_lo, dw[0], dw[1]);
        acc_p = 0;
        acc_d = 0;
        for (int a = 0; a < 2; a++) begin
            for (int b = 0; b < 2; b++) begin
                wp = ew[a] * dw[b];
                acc_p += wp * KP_RULES[(e_lo + a) * 7 + d_lo + b];
                acc_d += wp * KD_RULES[(e_lo + a) * 7 + d_lo + b];
            end
        end
        r.prop  = saturate_gain(kp_base_q8 + (kp_span_q8 * acc_p) / FULL_SCALE);
        r.deriv = saturate_gain(kd_base_q8 + (kd_span_q8 * acc_d) / FULL_SCALE);
        return r;
    endfunction

    // Random error: mostly sequences that wander, swap sign or stay small
    function automatic logic [15:0] next_error();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 16'($urandom);
        if (roll < 60)
            return sent_error + 16'($urandom_range(0, 8)) - 16'd4;
        if (roll < 85)
            return 16'($urandom_range(0, 128)) - 16'd64;
        return -sent_error;
    endfunction

    // Offer one error sample, after an optional idle burst
    task automatic send_error(input logic [15:0] sample, input logic pinned,
                              input t_gain_pair known);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tdata = sample;
        pin_valid = pinned;
        pin_gains = known;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_error = sample;
        @(negedge i_clk);
    endtask

    task automatic write_register(input fpgs_pkg::t_cfg_idx idx, input logic [31:0] value);
        i_cfg_index = idx;
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // Write every register, plus one write to an unused index
    task automatic program_gains(input logic [31:0] e_scale, input logic [31:0] r_scale,
                                 input logic [15:0] p_span, input logic [15:0] d_span,
                                 input logic [15:0] p_base, input logic [15:0] d_base);
        write_register(fpgs_pkg::CFG_KD_BASE, {16'($urandom_range(0, 65535)), d_base});
        write_register(fpgs_pkg::CFG_ERROR_SCALE, e_scale);
        write_register($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom);
        write_register(fpgs_pkg::CFG_RATE_SCALE, r_scale);
        write_register(fpgs_pkg::CFG_KP_SPAN, {16'($urandom_range(0, 65535)), p_span});
        write_register(fpgs_pkg::CFG_KD_SPAN, {16'h0000, d_span});
        write_register(fpgs_pkg::CFG_KP_BASE, {16'hFFFF, p_base});
        i_cfg_valid = 1'b0;
    endtask

    // Wait until every predicted result has been taken
    task automatic drain_results();
        while (pending_gains.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result sink: ready in random bursts, always ready in the calm stretch
    always @(negedge i_clk) begin
        if (calm) begin
            m_axis_tready = 1'b1;
        end else if (sink_burst > 0) begin
            sink_burst = sink_burst - 1;
        end else begin
            m_axis_tready = ($urandom_range(0, 2) != 0);
            sink_burst = m_axis_tready ? $urandom_range(0, 30) : $urandom_range(0, 18);
        end
    end

    // Track registers, predict on each item taken, check each result taken
    always @(posedge i_clk) begin : scoreboard
        t_gain_pair want;
        bit         moved;
        moved = 0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                moved = 1;
                if (pending_gains.size() == 0) begin
                    $error("result with no prediction waiting: tdata %h", m_axis_tdata);
                    fault_count++;
                end else begin
                    want = pending_gains.pop_front();
                    if (m_axis_tdata[16:0] !== want.prop) begin
                        $error("prop_gain: expected %0d, got %0d",
                               want.prop, m_axis_tdata[16:0]);
                        fault_count++;
                    end
                    if (m_axis_tdata[33:17] !== want.deriv) begin
                        $error("deriv_gain: expected %0d, got %0d",
                               want.deriv, m_axis_tdata[33:17]);
                        fault_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                moved = 1;
                want = pin_valid ? pin_gains : schedule_gains(s_axis_tdata);
                pending_gains.push_back(want);
                held_error = s_axis_tdata;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1;
                case (i_cfg_index)
                    fpgs_pkg::CFG_ERROR_SCALE: error_scale_q16 = i_cfg_data;
                    fpgs_pkg::CFG_RATE_SCALE:  rate_scale_q16  = i_cfg_data;
                    fpgs_pkg::CFG_KP_SPAN:     kp_span_q8      = i_cfg_data[15:0];
                    fpgs_pkg::CFG_KD_SPAN:     kd_span_q8      = i_cfg_data[15:0];
                    fpgs_pkg::CFG_KP_BASE:     kp_base_q8      = i_cfg_data[15:0];
                    fpgs_pkg::CFG_KD_BASE:     kd_base_q8      = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Watchdog: give up when nothing has moved for too long
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("fuzzy_pd_gain_scheduler verification failed");
        $finish;
    end

    // Stimulus
    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = fpgs_pkg::CFG_ERROR_SCALE;
        i_cfg_data = '0;
        pin_valid = 1'b0;
        pin_gains = '0;
        sent_error = '0;
        calm = 0;
        sink_burst = 0;
        idle_cycles = 0;
        fault_count = 0;
        error_scale_q16 = fpgs_pkg::ERROR_SCALE_RST;
        rate_scale_q16 = fpgs_pkg::RATE_SCALE_RST;
        kp_span_q8 = fpgs_pkg::KP_SPAN_RST;
        kd_span_q8 = fpgs_pkg::KD_SPAN_RST;
        kp_base_q8 = fpgs_pkg::KP_BASE_RST;
        kd_base_q8 = fpgs_pkg::KD_BASE_RST;
        held_error = '0;

        // Hold reset, release on a falling edge
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Opening table under the reset settings
        for (int k = 0; k < OPENING_COUNT; k++)
            send_error(OPENING_STEPS[k].sample, OPENING_STEPS[k].pinned,
                       {OPENING_STEPS[k].prop, OPENING_STEPS[k].deriv});

        // Random sequences, one register setting per phase
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            s_axis_tvalid = 1'b0;
            drain_results();
            case (phase)
                0: program_gains(32'd12, 32'd3, 16'd512, 16'd2560, 16'd256, 16'd128);
                1: program_gains('0, '0, '0, '0, '1, '1);
                2: program_gains('1, '1, '1, '1, '0, '0);
                3: program_gains(32'd12, 32'd3, '1, '1, '1, '1);
                4: program_gains($urandom_range(0, 64), $urandom_range(0, 16),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
                default: program_gains(fpgs_pkg::ERROR_SCALE_RST, fpgs_pkg::RATE_SCALE_RST,
                                       fpgs_pkg::KP_SPAN_RST, fpgs_pkg::KD_SPAN_RST,
                                       fpgs_pkg::KP_BASE_RST, fpgs_pkg::KD_BASE_RST);
            endcase
            for (int n = 0; n < STEPS_PER_PHASE; n++) begin
                calm = (phase == NUM_PHASES - 1) && (n >= STEPS_PER_PHASE - CALM_STEPS);
                send_error(next_error(), 1'b0, '0);
            end
        end
        s_axis_tvalid = 1'b0;

        // Collect the tail and let any stray result show up
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && pending_gains.size() == 0)
            $display("fuzzy_pd_gain_scheduler verification clean");
        else
            $display("fuzzy_pd_gain_scheduler verification failed");
        $finish;
    end

endmodule
